[src/jas_pkg.sv]
// shared constants, register indexes and controller/datapath interface types
package jas_pkg;

	// default widths of the voltage and button fields
	localparam int MV_BITS_DEF      = 12;
	localparam int BUTTON_COUNT_DEF = 6;

	// axes handled per poll
	localparam int AXES   = 4;
	localparam int AXIS_W = $clog2(AXES);

	// register and field widths
	localparam int RANGE_W    = 10;
	localparam int THR_W      = 10;
	localparam int GAP_W      = 16;
	localparam int TIME_W     = 32;
	localparam int OUT_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// quotient magnitude stays at most twice the full scale
	localparam int QUOT_W = RANGE_W + 1;
	localparam int ITER_W = $clog2(QUOT_W);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ANNOUNCE    = 3'd4;

	// register reset values
	localparam logic [RANGE_W-1:0] FULL_SCALE_RST = 10'd100;
	localparam logic [THR_W-1:0]   MOVE_THR_RST   = 10'd20;
	localparam logic [GAP_W-1:0]   MIN_GAP_RST    = 16'd10;
	localparam logic [GAP_W-1:0]   MAX_GAP_RST    = 16'd200;
	localparam logic [GAP_W-1:0]   ANNOUNCE_RST   = 16'd1000;

	// commands from the controller to the datapath
	typedef struct packed {
		logic              load;
		logic              ann;
		logic              minmax;
		logic              half;
		logic              diff;
		logic              mul;
		logic              divinit;
		logic              divstep;
		logic              fin;
		logic              send;
		logic              out;
		logic [AXIS_W-1:0] axis;
	} jas_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic half_zero;
		logic out_free;
	} jas_status_t;

endpackage

[src/jas_ctrl.sv]
// sequencing state machine: announce, per-axis scale and divide, report, output
module jas_ctrl import jas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  jas_status_t status,
	output jas_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ANN     = 4'd1;
	localparam logic [3:0] S_MINMAX  = 4'd2;
	localparam logic [3:0] S_HALF    = 4'd3;
	localparam logic [3:0] S_DIFF    = 4'd4;
	localparam logic [3:0] S_MUL     = 4'd5;
	localparam logic [3:0] S_DIVINIT = 4'd6;
	localparam logic [3:0] S_DIV     = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;
	localparam logic [3:0] S_SEND    = 4'd9;
	localparam logic [3:0] S_OUT     = 4'd10;

	logic [3:0]        state_q, state_nxt;
	logic [AXIS_W-1:0] axis_q, axis_nxt;
	logic [ITER_W-1:0] iter_q, iter_nxt;

	assign in_ready = (state_q == S_IDLE);

	// next state and command decode
	always_comb begin
		state_nxt   = state_q;
		axis_nxt    = axis_q;
		iter_nxt    = iter_q;
		cmd         = '0;
		cmd.axis    = axis_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_ANN;
				end
			end
			S_ANN: begin
				cmd.ann   = 1'b1;
				axis_nxt  = '0;
				state_nxt = S_MINMAX;
			end
			S_MINMAX: begin
				cmd.minmax = 1'b1;
				state_nxt  = S_HALF;
			end
			S_HALF: begin
				cmd.half  = 1'b1;
				state_nxt = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff  = 1'b1;
				state_nxt = S_MUL;
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_DIVINIT;
			end
			S_DIVINIT: begin
				cmd.divinit = 1'b1;
				iter_nxt    = '0;
				state_nxt   = status.half_zero ? S_FIN : S_DIV;
			end
			S_DIV: begin
				cmd.divstep = 1'b1;
				iter_nxt    = iter_q + 1'b1;
				if (iter_q == ITER_W'(QUOT_W - 1)) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				if (axis_q == AXIS_W'(AXES - 1)) begin
					state_nxt = S_SEND;
				end else begin
					axis_nxt  = axis_q + 1'b1;
					state_nxt = S_MINMAX;
				end
			end
			S_SEND: begin
				cmd.send  = 1'b1;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_nxt;
			axis_q  <= axis_nxt;
			iter_q  <= iter_nxt;
		end
	end

endmodule

[src/jas_datapath.sv]
// calibration store, scaling multiplier, shared divider, timing compares and output register
module jas_datapath import jas_pkg::*; #(
	parameter int MV_BITS      = MV_BITS_DEF,
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic [TIME_W-1:0]           now_ms,
	input  logic [MV_BITS-1:0]          left_x_mv,
	input  logic [MV_BITS-1:0]          left_y_mv,
	input  logic [MV_BITS-1:0]          right_x_mv,
	input  logic [MV_BITS-1:0]          right_y_mv,
	input  logic [BUTTON_COUNT-1:0]     buttons,
	input  jas_cmd_t                    cmd,
	output jas_status_t                 status,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic signed [OUT_W-1:0]     left_x,
	output logic signed [OUT_W-1:0]     left_y,
	output logic signed [OUT_W-1:0]     right_x,
	output logic signed [OUT_W-1:0]     right_y,
	output logic [BUTTON_COUNT-1:0]     button_bits,
	output logic                        changed,
	output logic                        send_state,
	output logic                        send_announce
);

	localparam int HALF_W = MV_BITS - 1;
	localparam int DIFF_W = MV_BITS + 1;
	localparam int PROD_W = DIFF_W + RANGE_W + 1;
	localparam int MAG_W  = PROD_W - 1;

	// configuration registers
	logic [RANGE_W-1:0] full_scale_q;
	logic [THR_W-1:0]   move_thr_q;
	logic [GAP_W-1:0]   min_gap_q;
	logic [GAP_W-1:0]   max_gap_q;
	logic [GAP_W-1:0]   announce_q;

	// captured item
	logic [TIME_W-1:0]       now_q;
	logic [BUTTON_COUNT-1:0] btn_q;
	logic [MV_BITS-1:0]      mv_q [AXES];

	// calibration and history state
	logic [MV_BITS-1:0]      low_q  [AXES];
	logic [MV_BITS-1:0]      high_q [AXES];
	logic signed [OUT_W-1:0] prev_q [AXES];
	logic [BUTTON_COUNT-1:0] prev_btn_q;
	logic [TIME_W-1:0]       last_send_q;
	logic [TIME_W-1:0]       last_ann_q;

	// working registers
	logic [HALF_W-1:0]        half_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     neg_q;
	logic [HALF_W-1:0]        rem_q;
	logic [QUOT_W-1:0]        dvd_q;
	logic signed [OUT_W-1:0]  scaled_q [AXES];
	logic                     chg_q;
	logic                     ann_q;
	logic                     send_q;

	// output register
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  left_x_q, left_y_q, right_x_q, right_y_q;
	logic [BUTTON_COUNT-1:0]  button_bits_q;
	logic                     changed_q, send_state_q, send_announce_q;

	// combinational helpers
	logic [MV_BITS-1:0]       mv_sel, low_sel, high_sel, span;
	logic signed [DIFF_W-1:0] diff_nxt;
	logic signed [PROD_W-1:0] prod_nxt;
	logic [PROD_W-1:0]        mag;
	logic [HALF_W:0]          trial, trial_sub;
	logic                     trial_ge;
	logic signed [OUT_W-1:0]  quot_ext, scaled_nxt;
	logic signed [OUT_W:0]    move_d;
	logic [OUT_W:0]           move_abs;
	logic                     moved;
	logic [TIME_W-1:0]        ann_since, send_since;

	assign mv_sel   = mv_q[cmd.axis];
	assign low_sel  = low_q[cmd.axis];
	assign high_sel = high_q[cmd.axis];
	assign span     = high_sel - low_sel;

	// offset from the centre: mv - low - half
	assign diff_nxt = $signed({1'b0, mv_sel}) - $signed({1'b0, low_sel})
	                - $signed({2'b00, half_q});
	assign prod_nxt = diff_q * $signed({1'b0, full_scale_q});
	assign mag      = prod_q[PROD_W-1] ? (-prod_q) : prod_q;

	// restoring divide step
	assign trial     = {rem_q, dvd_q[QUOT_W-1]};
	assign trial_sub = trial - {1'b0, half_q};
	assign trial_ge  = (trial >= {1'b0, half_q});

	// signed quotient and movement against the last value
	assign quot_ext   = OUT_W'(dvd_q);
	assign scaled_nxt = neg_q ? (-quot_ext) : quot_ext;
	assign move_d     = $signed({scaled_nxt[OUT_W-1], scaled_nxt})
	                  - $signed({prev_q[cmd.axis][OUT_W-1], prev_q[cmd.axis]});
	assign move_abs   = move_d[OUT_W] ? (-move_d) : move_d;
	assign moved      = (move_abs > (OUT_W+1)'(move_thr_q));

	// elapsed times, modulo 2^32
	assign ann_since  = now_q - last_ann_q;
	assign send_since = now_q - last_send_q;

	assign status.half_zero = (half_q == '0);
	assign status.out_free  = !out_valid_q || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RST;
			move_thr_q   <= MOVE_THR_RST;
			min_gap_q    <= MIN_GAP_RST;
			max_gap_q    <= MAX_GAP_RST;
			announce_q   <= ANNOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FULL_SCALE: full_scale_q <= cfg_data[RANGE_W-1:0];
				REG_MOVE_THR:   move_thr_q   <= cfg_data[THR_W-1:0];
				REG_MIN_GAP:    min_gap_q    <= cfg_data[GAP_W-1:0];
				REG_MAX_GAP:    max_gap_q    <= cfg_data[GAP_W-1:0];
				REG_ANNOUNCE:   announce_q   <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q   <= now_ms;
			btn_q   <= buttons;
			mv_q[0] <= left_x_mv;
			mv_q[1] <= left_y_mv;
			mv_q[2] <= right_x_mv;
			mv_q[3] <= right_y_mv;
		end
		if (cmd.half) begin
			half_q <= span[MV_BITS-1:1];
		end
		if (cmd.diff) begin
			diff_q <= diff_nxt;
		end
		if (cmd.mul) begin
			prod_q <= prod_nxt;
		end
		if (cmd.divinit) begin
			neg_q <= prod_q[PROD_W-1];
			if (status.half_zero) begin
				rem_q <= '0;
				dvd_q <= '0;
			end else begin
				rem_q <= HALF_W'(mag[MAG_W-1:QUOT_W]);
				dvd_q <= mag[QUOT_W-1:0];
			end
		end
		if (cmd.divstep) begin
			rem_q <= trial_ge ? trial_sub[HALF_W-1:0] : trial[HALF_W-1:0];
			dvd_q <= {dvd_q[QUOT_W-2:0], trial_ge};
		end
		if (cmd.fin) begin
			scaled_q[cmd.axis] <= scaled_nxt;
		end
	end

	// calibration range, history and report timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				low_q[i]  <= '0;
				high_q[i] <= '0;
				prev_q[i] <= '0;
			end
			prev_btn_q  <= '0;
			last_send_q <= '0;
			last_ann_q  <= '0;
			chg_q       <= 1'b0;
			ann_q       <= 1'b0;
			send_q      <= 1'b0;
		end else begin
			if (cmd.ann) begin
				ann_q      <= (ann_since > TIME_W'(announce_q));
				if (ann_since > TIME_W'(announce_q)) begin
					last_ann_q <= now_q;
				end
				chg_q      <= (btn_q != prev_btn_q);
				prev_btn_q <= btn_q;
			end
			if (cmd.minmax) begin
				if (mv_sel < low_sel) begin
					low_q[cmd.axis] <= mv_sel;
				end
				if (mv_sel > high_sel) begin
					high_q[cmd.axis] <= mv_sel;
				end
			end
			if (cmd.fin) begin
				prev_q[cmd.axis] <= scaled_nxt;
				if (moved) begin
					chg_q <= 1'b1;
				end
			end
			if (cmd.send) begin
				send_q <= (chg_q && (send_since > TIME_W'(min_gap_q)))
				       || (send_since > TIME_W'(max_gap_q));
				if ((chg_q && (send_since > TIME_W'(min_gap_q)))
				    || (send_since > TIME_W'(max_gap_q))) begin
					last_send_q <= now_q;
				end
			end
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.out) begin
			left_x_q        <= scaled_q[0];
			left_y_q        <= scaled_q[1];
			right_x_q       <= scaled_q[2];
			right_y_q       <= scaled_q[3];
			button_bits_q   <= btn_q;
			changed_q       <= chg_q;
			send_state_q    <= send_q;
			send_announce_q <= ann_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_x        = left_x_q;
	assign left_y        = left_y_q;
	assign right_x       = right_x_q;
	assign right_y       = right_y_q;
	assign button_bits   = button_bits_q;
	assign changed       = changed_q;
	assign send_state    = send_state_q;
	assign send_announce = send_announce_q;

endmodule

[src/joystick_autocal_sampler_top.sv]
// top level of the auto-calibrating joystick sampler
//
// One input item per poll: time in ms, four stick voltages in mV and a
// button mask, on a valid/ready channel. One result item per poll: the four
// scaled axes, the buttons, and the changed, send_state and send_announce
// flags, on a valid/ready channel held in an output register.
// Each axis widens its stored min/max range, is centred and multiplied by
// the full-scale register, then divided by the half span in a shared
// restoring divider that produces one quotient bit per cycle.
// An axis with a zero half span skips its divide. The block works on one item
// at a time and takes the next item only once the previous result has moved
// into the output register.
// A finished result waits in the output register while the receiver stalls;
// the next item is accepted and processed meanwhile, holding only at the
// final output step until the register is free.
// Configuration is a write-only port (enable, index, data), taken at once.
// Reset restores the register defaults and clears the calibration ranges,
// the last axis values, the last buttons and both time stamps.
module joystick_autocal_sampler_top import jas_pkg::*; #(
	parameter int MV_BITS      = MV_BITS_DEF,
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [TIME_W-1:0]       now_ms,
	input  logic [MV_BITS-1:0]      left_x_mv,
	input  logic [MV_BITS-1:0]      left_y_mv,
	input  logic [MV_BITS-1:0]      right_x_mv,
	input  logic [MV_BITS-1:0]      right_y_mv,
	input  logic [BUTTON_COUNT-1:0] buttons,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] left_x,
	output logic signed [OUT_W-1:0] left_y,
	output logic signed [OUT_W-1:0] right_x,
	output logic signed [OUT_W-1:0] right_y,
	output logic [BUTTON_COUNT-1:0] button_bits,
	output logic                    changed,
	output logic                    send_state,
	output logic                    send_announce
);

	jas_cmd_t    cmd;
	jas_status_t status;

	// sequencer
	jas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	jas_datapath #(
		.MV_BITS      (MV_BITS),
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.now_ms        (now_ms),
		.left_x_mv     (left_x_mv),
		.left_y_mv     (left_y_mv),
		.right_x_mv    (right_x_mv),
		.right_y_mv    (right_y_mv),
		.buttons       (buttons),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.left_x        (left_x),
		.left_y        (left_y),
		.right_x       (right_x),
		.right_y       (right_y),
		.button_bits   (button_bits),
		.changed       (changed),
		.send_state    (send_state),
		.send_announce (send_announce)
	);

endmodule

[src/jas_checker.sv]
// port-level checks for the sampler, bound to the top level
module jas_checker import jas_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] left_x
);

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// a stalled result item keeps its left_x value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_x))
		else $error("result payload changed while stalled");

	// one item at a time: ready drops after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	// a new result appears only as the sequencer returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result item raised outside the final step");

endmodule

bind joystick_autocal_sampler_top jas_checker u_jas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.left_x    (left_x)
);

[bench/tb_joystick_autocal_sampler_top.sv]
// self-checking testbench for the auto-calibrating joystick sampler
module tb_joystick_autocal_sampler_top;
	import jas_pkg::*;

	localparam int MV_W          = MV_BITS_DEF;
	localparam int BTN_W         = BUTTON_COUNT_DEF;
	localparam int RANDOM_POLLS  = 950;
	localparam int PHASES        = 5;
	localparam int SETTLE_CYCLES = 80;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int CYCLE_LIMIT   = 1500000;

	// one poll as offered on the input channel
	typedef struct packed {
		logic [TIME_W-1:0]         now;
		logic [AXES-1:0][MV_W-1:0] mv;
		logic [BTN_W-1:0]          btn;
	} poll_t;

	// one report as seen on the output channel
	typedef struct packed {
		logic [AXES-1:0][OUT_W-1:0] axis;
		logic [BTN_W-1:0]           btn;
		logic                       chg;
		logic                       rep;
		logic                       ann;
	} report_t;

	// directed row: poll, then the typed report where it is obvious
	typedef struct packed {
		logic [TIME_W-1:0]       now;
		logic [MV_W-1:0]         lx, ly, rx, ry;
		logic [BTN_W-1:0]        btn;
		logic                    typed;
		logic signed [OUT_W-1:0] elx, ely, erx, ery;
		logic [2:0]              flags;
	} row_t;

	// flags are {changed, send_state, send_announce}
	localparam row_t POLL_TABLE [20] = '{
		// zero half span straight after reset
		'{32'd0, 0, 0, 0, 0, 6'd0, 1'b1, 0, 0, 0, 0, 3'b000},
		'{32'd2, 1, 1, 1, 1, 6'd0, 1'b1, 0, 0, 0, 0, 3'b000},
		// full span opens up, then the low extreme
		'{32'd5, 4095, 4095, 4095, 4095, 6'd63, 1'b1, 100, 100, 100, 100, 3'b100},
		'{32'd15, 0, 0, 0, 0, 6'd63, 1'b1, -100, -100, -100, -100, 3'b110},
		// change exactly at the short gap is not sent
		'{32'd25, 2047, 2047, 2047, 2047, 6'd63, 1'b1, 0, 0, 0, 0, 3'b100},
		'{32'd26, 2047, 2047, 2047, 2047, 6'd63, 1'b1, 0, 0, 0, 0, 3'b000},
		// long gap boundary
		'{32'd215, 2047, 2047, 2047, 2047, 6'd63, 1'b1, 0, 0, 0, 0, 3'b000},
		'{32'd216, 2047, 2047, 2047, 2047, 6'd63, 1'b1, 0, 0, 0, 0, 3'b010},
		// move equal to the threshold, then one past it with the announce
		'{32'd1000, 2457, 2047, 2047, 2047, 6'd63, 1'b1, 20, 0, 0, 0, 3'b010},
		'{32'd1001, 2887, 2047, 2047, 2047, 6'd63, 1'b1, 41, 0, 0, 0, 3'b101},
		// announce period boundary
		'{32'd2001, 2047, 2047, 2047, 2047, 6'd0, 1'b1, 0, 0, 0, 0, 3'b110},
		'{32'd2002, 2047, 2047, 2047, 2047, 6'd0, 1'b1, 0, 0, 0, 0, 3'b001},
		// time wrapping and field extremes
		'{32'hFFFF_FFF0, 100, 4000, 3000, 1200, 6'h15, 1'b0, 0, 0, 0, 0, 3'b000},
		'{32'h0000_0005, 4095, 0, 2048, 2046, 6'h2A, 1'b0, 0, 0, 0, 0, 3'b000},
		'{32'hFFFF_FFFF, 1, 4094, 2047, 0, 6'h01, 1'b0, 0, 0, 0, 0, 3'b000},
		'{32'h7FFF_FFFF, 3071, 1023, 0, 4095, 6'h20, 1'b0, 0, 0, 0, 0, 3'b000},
		'{32'h8000_0000, 2047, 2047, 2047, 2047, 6'h20, 1'b0, 0, 0, 0, 0, 3'b000},
		'{32'h8000_0001, 2067, 2027, 2068, 2026, 6'h20, 1'b0, 0, 0, 0, 0, 3'b000},
		'{32'hAAAA_AAAA, 2730, 1365, 2730, 1365, 6'h3F, 1'b0, 0, 0, 0, 0, 3'b000},
		'{32'h5555_5555, 1365, 2730, 1365, 2730, 6'h00, 1'b0, 0, 0, 0, 0, 3'b000}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [TIME_W-1:0]       now_ms;
	logic [MV_W-1:0]         left_x_mv, left_y_mv, right_x_mv, right_y_mv;
	logic [BTN_W-1:0]        buttons;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [OUT_W-1:0] left_x, left_y, right_x, right_y;
	logic [BTN_W-1:0]        button_bits;
	logic                    changed, send_state, send_announce;

	// predictor copy of the registers and the calibration state
	logic [RANGE_W-1:0] full_scale      = FULL_SCALE_RST;
	logic [THR_W-1:0]   move_thr        = MOVE_THR_RST;
	logic [GAP_W-1:0]   min_gap         = MIN_GAP_RST;
	logic [GAP_W-1:0]   max_gap         = MAX_GAP_RST;
	logic [GAP_W-1:0]   announce_period = ANNOUNCE_RST;
	int                 cal_low [AXES];
	int                 cal_high [AXES];
	int                 last_scaled [AXES];
	logic [BTN_W-1:0]   last_buttons     = '0;
	logic [TIME_W-1:0]  last_report_ms   = '0;
	logic [TIME_W-1:0]  last_announce_ms = '0;

	report_t pending_reports [$];
	string   axis_names [AXES] = '{"left_x", "left_y", "right_x", "right_y"};
	int      error_count   = 0;
	int      polls_sent    = 0;
	int      states_seen   = 0;
	int      announces_seen = 0;
	int      changes_seen  = 0;
	int      burst_left    = 0;
	int      cycle_count   = 0;
	logic [31:0] stall_pattern = '1;
	logic [5:0]  stall_tick    = '0;

	joystick_autocal_sampler_top u_dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// register write as the block sees it
	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FULL_SCALE: full_scale = data[RANGE_W-1:0];
			REG_MOVE_THR: move_thr = data[THR_W-1:0];
			REG_MIN_GAP: min_gap = data;
			REG_MAX_GAP: max_gap = data;
			REG_ANNOUNCE: announce_period = data;
			default: ;
		endcase
	endtask

	// widen the range, scale each axis, flag changes and decide the sends
	task automatic predict_report(input poll_t p, output report_t r);
		logic [TIME_W-1:0] since;
		int                mv, half, centre, q, d;
		longint            num;
		since = p.now - last_announce_ms;
		r.ann = since > {16'd0, announce_period};
		if (r.ann)
			last_announce_ms = p.now;
		r.chg = (p.btn != last_buttons);
		for (int i = 0; i < AXES; i++) begin
			mv = int'(p.mv[i]);
			if (mv < cal_low[i])
				cal_low[i] = mv;
			if (mv > cal_high[i])
				cal_high[i] = mv;
			half = (cal_high[i] - cal_low[i]) / 2;
			centre = cal_low[i] + half;
			if (half == 0) begin
				q = 0;
			end else begin
				num = longint'(mv - centre) * longint'(full_scale);
				q = int'(num / half);
				if (q > 2047)
					q = 2047;
				if (q < -2048)
					q = -2048;
			end
			d = q - last_scaled[i];
			if (d < 0)
				d = -d;
			if (d > int'(move_thr))
				r.chg = 1'b1;
			last_scaled[i] = q;
			r.axis[i] = q[OUT_W-1:0];
		end
		last_buttons = p.btn;
		since = p.now - last_report_ms;
		r.rep = (r.chg && since > {16'd0, min_gap}) || since > {16'd0, max_gap};
		if (r.rep)
			last_report_ms = p.now;
		r.btn = p.btn;
	endtask

	// offer one poll, record its report, then maybe idle between bursts
	task automatic offer_poll(input poll_t p, input logic typed, input report_t typed_want);
		report_t predicted;
		int      gap;
		in_valid   <= 1'b1;
		now_ms     <= p.now;
		left_x_mv  <= p.mv[0];
		left_y_mv  <= p.mv[1];
		right_x_mv <= p.mv[2];
		right_y_mv <= p.mv[3];
		buttons    <= p.btn;
		do @(posedge clk); while (!in_ready);
		predict_report(p, predicted);
		pending_reports.push_back(typed ? typed_want : predicted);
		polls_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every report is back and the block has gone quiet
	task automatic drain_reports();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reports.size() != 0) begin
			$error("%0d report items never arrived", pending_reports.size());
			error_count++;
			pending_reports.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	// register setting per phase, extremes first, junk to unused indexes each time
	task automatic load_settings(input int phase);
		case (phase)
			0: ;
			1: begin
				write_reg(REG_FULL_SCALE, 16'd1000);
				write_reg(REG_MOVE_THR, 16'd0);
				write_reg(REG_MIN_GAP, 16'd0);
				write_reg(REG_MAX_GAP, 16'd0);
				write_reg(REG_ANNOUNCE, 16'd0);
			end
			2: begin
				write_reg(REG_FULL_SCALE, 16'd1);
				write_reg(REG_MOVE_THR, 16'd1000);
				write_reg(REG_MIN_GAP, 16'hFFFF);
				write_reg(REG_MAX_GAP, 16'hFFFF);
				write_reg(REG_ANNOUNCE, 16'hFFFF);
			end
			default: begin
				write_reg(REG_FULL_SCALE, CFG_DATA_W'($urandom_range(1, 1000)));
				write_reg(REG_MOVE_THR, CFG_DATA_W'($urandom_range(0, 60)));
				write_reg(REG_MIN_GAP, CFG_DATA_W'($urandom_range(0, 40)));
				write_reg(REG_MAX_GAP, CFG_DATA_W'($urandom_range(0, 500)));
				write_reg(REG_ANNOUNCE, CFG_DATA_W'($urandom_range(0, 2000)));
			end
		endcase
		for (int k = REG_ANNOUNCE + 1; k < 2 ** CFG_IDX_W; k++)
			write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// next poll: mostly a stick drifting in time, sometimes noise
	function automatic poll_t wander(input poll_t prev);
		poll_t p;
		int    v;
		p = prev;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: p.now = prev.now + $urandom_range(0, 30);
			6, 7: p.now = prev.now + $urandom_range(0, 400);
			8: p.now = prev.now + $urandom_range(0, 70000);
			default: p.now = $urandom;
		endcase
		if ($urandom_range(0, 9) < 7) begin
			for (int i = 0; i < AXES; i++) begin
				v = int'(prev.mv[i]) + int'($urandom_range(0, 120)) - 60;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				p.mv[i] = v[MV_W-1:0];
			end
			if ($urandom_range(0, 4) == 0)
				p.btn = p.btn ^ (BTN_W'(1) << $urandom_range(0, BTN_W - 1));
		end else begin
			for (int i = 0; i < AXES; i++) begin
				case ($urandom_range(0, 2))
					0: p.mv[i] = '0;
					1: p.mv[i] = '1;
					default: p.mv[i] = MV_W'($urandom);
				endcase
			end
			p.btn = BTN_W'($urandom);
		end
		return p;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// receiver stalls on a rotating pattern, reloaded whenever the tick counter wraps
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (stall_tick == '0)
			stall_pattern <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
		out_ready <= stall_pattern[stall_tick[4:0]];
	end

	// compare each report item with the oldest prediction
	always @(posedge clk) begin
		report_t got, want;
		if (out_valid && out_ready) begin
			got.axis[0] = left_x;
			got.axis[1] = left_y;
			got.axis[2] = right_x;
			got.axis[3] = right_y;
			got.btn = button_bits;
			got.chg = changed;
			got.rep = send_state;
			got.ann = send_announce;
			states_seen += got.rep;
			announces_seen += got.ann;
			changes_seen += got.chg;
			if (pending_reports.size() == 0) begin
				$error("report item with none expected");
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				for (int i = 0; i < AXES; i++)
					check_field(axis_names[i], int'($signed(want.axis[i])),
						int'($signed(got.axis[i])));
				check_field("button_bits", int'(want.btn), int'(got.btn));
				check_field("changed", int'(want.chg), int'(got.chg));
				check_field("send_state", int'(want.rep), int'(got.rep));
				check_field("send_announce", int'(want.ann), int'(got.ann));
			end
		end
	end

	// overall timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_joystick_autocal_sampler_top: errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		poll_t   p;
		report_t want;
		row_t    row;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_FULL_SCALE;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		now_ms     <= '0;
		left_x_mv  <= '0;
		left_y_mv  <= '0;
		right_x_mv <= '0;
		right_y_mv <= '0;
		buttons    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed polls under the reset settings, unused indexes scribbled first
		load_settings(0);
		for (int r = 0; r < $size(POLL_TABLE); r++) begin
			row = POLL_TABLE[r];
			p.now = row.now;
			p.mv[0] = row.lx;
			p.mv[1] = row.ly;
			p.mv[2] = row.rx;
			p.mv[3] = row.ry;
			p.btn = row.btn;
			want.axis[0] = row.elx;
			want.axis[1] = row.ely;
			want.axis[2] = row.erx;
			want.axis[3] = row.ery;
			want.btn = row.btn;
			{want.chg, want.rep, want.ann} = row.flags;
			offer_poll(p, row.typed, want);
		end
		drain_reports();

		// random polls, one block of them per register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			load_settings(phase);
			for (int n = 0; n < RANDOM_POLLS / PHASES; n++) begin
				p = wander(p);
				offer_poll(p, 1'b0, '0);
				if (phase == 3 && n == RANDOM_POLLS / PHASES / 2)
					drain_reports();
			end
			drain_reports();
		end

		$display("%0d polls over %0d register settings incl. both extremes and unused indexes",
			polls_sent, PHASES);
		$display("%0d state reports, %0d announces, %0d changes flagged",
			states_seen, announces_seen, changes_seen);
		if (error_count == 0)
			$display("tb_joystick_autocal_sampler_top: clean");
		else
			$display("tb_joystick_autocal_sampler_top: errors");
		$finish;
	end

endmodule
